// ----- hdl/kti_pkg.sv -----
// Package for the keyframe track interpolator: field widths, request and
// status codes, and the state types of the sequencer and the lerp unit.
// No dependencies.
package kti_pkg;

   localparam int DEF_MAX_KEYS     = 32;
   localparam int DEF_CHANNEL_BITS = 24;

   localparam int KEY_TIME_BITS    = 10;
   localparam int FRAC_BITS        = 8;
   localparam int EVAL_TIME_BITS   = KEY_TIME_BITS + FRAC_BITS;
   localparam int INDEX_BITS       = 5;
   localparam int COUNT_OUT_BITS   = 6;
   localparam int NUM_CH           = 6;
   localparam int CH_SEL_BITS      = 3;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_EVAL   = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
   localparam logic [1:0] STAT_FEW_KEYS  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_DECIDE,
      ST_INS_SHIFT,
      ST_INS_WRITE,
      ST_DEL_CHECK,
      ST_DEL_MOVE,
      ST_EV_SCAN,
      ST_EV_CLASS,
      ST_EV_GET_A,
      ST_EV_GET_B,
      ST_EV_CALC,
      ST_EV_WAIT,
      ST_FINISH
   } ctl_state_type;

   typedef enum logic [2:0] {
      L_IDLE,
      L_MUL,
      L_PREP,
      L_DIV,
      L_OUT
   } lerp_state_type;

endpackage

// ----- hdl/kti_if.sv -----
// Valid/ready channel interfaces for request and response transactions.
// Depends on kti_pkg.
interface kti_req_if import kti_pkg::*; #(parameter int CHANNEL_BITS = DEF_CHANNEL_BITS);
   logic                               valid;
   logic                               ready;
   logic [1:0]                         req_type;
   logic [KEY_TIME_BITS-1:0]           key_time;
   logic [INDEX_BITS-1:0]              remove_index;
   logic [EVAL_TIME_BITS-1:0]          eval_time;
   logic signed [CHANNEL_BITS-1:0]     in_pos_x;
   logic signed [CHANNEL_BITS-1:0]     in_pos_y;
   logic signed [CHANNEL_BITS-1:0]     in_pos_z;
   logic signed [CHANNEL_BITS-1:0]     in_yaw;
   logic signed [CHANNEL_BITS-1:0]     in_pitch;
   logic signed [CHANNEL_BITS-1:0]     in_fov;

   modport source (output valid, req_type, key_time, remove_index, eval_time,
                   in_pos_x, in_pos_y, in_pos_z, in_yaw, in_pitch, in_fov,
                   input ready);
   modport sink (input valid, req_type, key_time, remove_index, eval_time,
                 in_pos_x, in_pos_y, in_pos_z, in_yaw, in_pitch, in_fov,
                 output ready);
endinterface

interface kti_rsp_if import kti_pkg::*; #(parameter int CHANNEL_BITS = DEF_CHANNEL_BITS);
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic                               done_res;
   logic [COUNT_OUT_BITS-1:0]          key_count;
   logic signed [CHANNEL_BITS-1:0]     out_pos_x;
   logic signed [CHANNEL_BITS-1:0]     out_pos_y;
   logic signed [CHANNEL_BITS-1:0]     out_pos_z;
   logic signed [CHANNEL_BITS-1:0]     out_yaw;
   logic signed [CHANNEL_BITS-1:0]     out_pitch;
   logic signed [CHANNEL_BITS-1:0]     out_fov;

   modport source (output valid, status, done_res, key_count, out_pos_x, out_pos_y,
                   out_pos_z, out_yaw, out_pitch, out_fov, input ready);
   modport sink (input valid, status, done_res, key_count, out_pos_x, out_pos_y,
                 out_pos_z, out_yaw, out_pitch, out_fov, output ready);
endinterface

// ----- hdl/keyframe_track_interpolator.sv -----
// Top level: sequencer over the keyframe table memory and the lerp unit.
// Depends on kti_pkg, kti_if, kti_store and kti_lerp.
//
//   channel   direction  handshake          payload
//   req_bus   in         valid/ready        request type, times, index, six channels
//   rsp_bus   out        valid/ready        status, done, count, six channels
//
// Insert scans for the key's slot, then moves entries up one at a time; delete
// moves entries down one at a time; evaluate scans the table, loads two keys
// and runs the lerp unit per channel, whose divide gives one bit a cycle.
// One memory read port sets the scan and shift rates. Reset is synchronous
// and empties the table at once. A new request is taken while the previous
// response waits; a stalled response holds the next one in ST_FINISH.
module keyframe_track_interpolator import kti_pkg::*; #(
   parameter int MAX_KEYS     = DEF_MAX_KEYS,
   parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
   input logic     clock,
   input logic     reset,
   kti_req_if.sink   req_bus,
   kti_rsp_if.source rsp_bus
);
   localparam int AW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int CB = CHANNEL_BITS;
   localparam int EW = KEY_TIME_BITS + NUM_CH * CB;
   localparam int TL = EW - KEY_TIME_BITS;

   ctl_state_type state_ff, state_in;
   logic [CW-1:0]   cnt_ff, idx_ff, pos_ff;
   logic            found_ff, copy_ff, done_ff;
   logic [1:0]      type_ff, status_ff;
   logic [KEY_TIME_BITS-1:0] kt_ff, t0_ff, tl_ff;
   logic [EVAL_TIME_BITS-1:0] et_ff;
   logic [EW-1:0]   new_ff, a_ff, b_ff;
   logic [AW-1:0]   s_ff;
   logic [CH_SEL_BITS-1:0] ch_ff;
   logic signed [CB-1:0] res_ff [NUM_CH];

   logic            rsp_valid_ff;
   logic [1:0]      rsp_status_ff;
   logic            rsp_done_ff;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff;
   logic signed [CB-1:0] rsp_ch_ff [NUM_CH];

   logic            rd_en, wr_en;
   logic [AW-1:0]   rd_addr, wr_addr, sel_addr;
   logic [EW-1:0]   rd_data, wr_data;
   logic            accept, out_free, lerp_start, lerp_done;
   logic signed [CB-1:0] lerp_res;
   logic [KEY_TIME_BITS-1:0] rd_time;
   logic [CW-1:0]   last;
   logic [EVAL_TIME_BITS-1:0] rd_time_q, t0_q, tl_q, ta_q, tb_q;

   assign accept    = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign rd_time   = rd_data[EW-1:TL];
   assign last      = cnt_ff - CW'(1);
   assign rd_time_q = {rd_time, FRAC_BITS'(0)};
   assign t0_q      = {t0_ff, FRAC_BITS'(0)};
   assign tl_q      = {tl_ff, FRAC_BITS'(0)};
   assign ta_q      = {a_ff[EW-1:TL], FRAC_BITS'(0)};
   assign tb_q      = {b_ff[EW-1:TL], FRAC_BITS'(0)};

   always_comb begin
      priority if (et_ff <= t0_q) begin
         sel_addr = '0;
      end else if (et_ff > tl_q) begin
         sel_addr = last[AW-1:0];
      end else begin
         sel_addr = s_ff;
      end
   end

   kti_store #(.MAX_KEYS(MAX_KEYS), .CHANNEL_BITS(CB)) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   kti_lerp #(.CHANNEL_BITS(CB)) u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .a_val  (signed'(a_ff[ch_ff*CB +: CB])),
      .b_val  (signed'(b_ff[ch_ff*CB +: CB])),
      .num    (et_ff - ta_q),
      .den    (tb_q - ta_q),
      .done   (lerp_done),
      .result (lerp_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_bus.req_type)
                  REQ_INSERT: state_in = (cnt_ff == '0) ? ST_INS_DECIDE : ST_INS_SCAN;
                  REQ_DELETE: state_in = ((CW+INDEX_BITS)'(req_bus.remove_index) >=
                                          (CW+INDEX_BITS)'(cnt_ff)) ? ST_FINISH
                                                                    : ST_DEL_CHECK;
                  REQ_EVAL:   state_in = (cnt_ff < CW'(2)) ? ST_FINISH : ST_EV_SCAN;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_INS_SCAN: begin
            priority if (rd_time == kt_ff) begin
               state_in = ST_INS_WRITE;
            end else if (rd_time > kt_ff || idx_ff + CW'(1) == cnt_ff) begin
               state_in = ST_INS_DECIDE;
            end
         end
         ST_INS_DECIDE: begin
            priority if (cnt_ff >= CW'(MAX_KEYS)) begin
               state_in = ST_FINISH;
            end else if (cnt_ff == pos_ff) begin
               state_in = ST_INS_WRITE;
            end else begin
               state_in = ST_INS_SHIFT;
            end
         end
         ST_INS_SHIFT:  if (idx_ff - CW'(1) == pos_ff) state_in = ST_INS_WRITE;
         ST_INS_WRITE:  state_in = ST_FINISH;
         ST_DEL_CHECK:  state_in = (idx_ff + CW'(1) >= cnt_ff) ? ST_FINISH : ST_DEL_MOVE;
         ST_DEL_MOVE:   state_in = ST_DEL_CHECK;
         ST_EV_SCAN:    if (idx_ff == last) state_in = ST_EV_CLASS;
         ST_EV_CLASS:   state_in = ST_EV_GET_A;
         ST_EV_GET_A:   state_in = copy_ff ? ST_FINISH : ST_EV_GET_B;
         ST_EV_GET_B:   state_in = ST_EV_CALC;
         ST_EV_CALC:    state_in = ST_EV_WAIT;
         ST_EV_WAIT: begin
            if (lerp_done) begin
               state_in = (ch_ff == CH_SEL_BITS'(NUM_CH - 1)) ? ST_FINISH : ST_EV_CALC;
            end
         end
         ST_FINISH:     if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == ST_IDLE) && !reset;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = rd_data;
      lerp_start = (state_ff == ST_EV_CALC);
      unique case (state_ff)
         ST_IDLE: begin
            rd_en = accept && (req_bus.req_type == REQ_INSERT || req_bus.req_type == REQ_EVAL);
         end
         ST_INS_SCAN: begin
            rd_en   = (rd_time < kt_ff) && (idx_ff + CW'(1) != cnt_ff);
            rd_addr = AW'(idx_ff + CW'(1));
         end
         ST_INS_DECIDE: begin
            rd_en   = (cnt_ff < CW'(MAX_KEYS)) && (cnt_ff != pos_ff);
            rd_addr = AW'(cnt_ff - CW'(1));
         end
         ST_INS_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff);
            rd_en   = (idx_ff - CW'(1) != pos_ff);
            rd_addr = AW'(idx_ff - CW'(2));
         end
         ST_INS_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_ff);
            wr_data = new_ff;
         end
         ST_DEL_CHECK: begin
            rd_en   = (idx_ff + CW'(1) < cnt_ff);
            rd_addr = AW'(idx_ff + CW'(1));
         end
         ST_DEL_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff);
         end
         ST_EV_SCAN: begin
            rd_en   = (idx_ff != last);
            rd_addr = AW'(idx_ff + CW'(1));
         end
         ST_EV_CLASS: begin
            rd_en   = 1'b1;
            rd_addr = sel_addr;
         end
         ST_EV_GET_A: begin
            rd_en   = !copy_ff;
            rd_addr = AW'(s_ff + AW'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_INS_WRITE && !found_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (state_ff == ST_DEL_CHECK && idx_ff + CW'(1) >= cnt_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               type_ff   <= req_bus.req_type;
               kt_ff     <= req_bus.key_time;
               et_ff     <= req_bus.eval_time;
               new_ff    <= {req_bus.key_time, req_bus.in_fov, req_bus.in_pitch,
                             req_bus.in_yaw, req_bus.in_pos_z, req_bus.in_pos_y,
                             req_bus.in_pos_x};
               found_ff  <= 1'b0;
               pos_ff    <= '0;
               s_ff      <= '0;
               done_ff   <= 1'b0;
               status_ff <= STAT_OK;
               for (int c = 0; c < NUM_CH; c++) begin
                  res_ff[c] <= '0;
               end
               idx_ff <= (req_bus.req_type == REQ_DELETE) ? CW'(req_bus.remove_index) : '0;
               if (req_bus.req_type == REQ_DELETE &&
                   (CW+INDEX_BITS)'(req_bus.remove_index) >= (CW+INDEX_BITS)'(cnt_ff)) begin
                  status_ff <= STAT_BAD_INDEX;
               end
               if (req_bus.req_type == REQ_EVAL && cnt_ff < CW'(2)) begin
                  status_ff <= STAT_FEW_KEYS;
               end
            end
         end
         ST_INS_SCAN: begin
            priority if (rd_time == kt_ff) begin
               found_ff <= 1'b1;
               pos_ff   <= idx_ff;
            end else if (rd_time > kt_ff) begin
               pos_ff <= idx_ff;
            end else begin
               idx_ff <= idx_ff + CW'(1);
               pos_ff <= idx_ff + CW'(1);
            end
         end
         ST_INS_DECIDE: begin
            idx_ff <= cnt_ff;
            if (cnt_ff >= CW'(MAX_KEYS)) begin
               status_ff <= STAT_FULL;
            end
         end
         ST_INS_SHIFT: idx_ff <= idx_ff - CW'(1);
         ST_DEL_MOVE:  idx_ff <= idx_ff + CW'(1);
         ST_EV_SCAN: begin
            if (idx_ff == '0) begin
               t0_ff <= rd_time;
            end
            if (idx_ff != last && rd_time_q <= et_ff) begin
               s_ff <= AW'(idx_ff);
            end
            tl_ff  <= rd_time;
            idx_ff <= idx_ff + CW'(1);
         end
         ST_EV_CLASS: begin
            s_ff    <= sel_addr;
            copy_ff <= (et_ff <= t0_q) || (et_ff > tl_q);
            done_ff <= (et_ff > tl_q) && !(et_ff <= t0_q);
         end
         ST_EV_GET_A: begin
            a_ff <= rd_data;
            if (copy_ff) begin
               for (int c = 0; c < NUM_CH; c++) begin
                  res_ff[c] <= signed'(rd_data[c*CB +: CB]);
               end
            end
         end
         ST_EV_GET_B: begin
            b_ff  <= rd_data;
            ch_ff <= '0;
         end
         ST_EV_WAIT: begin
            if (lerp_done) begin
               res_ff[ch_ff] <= lerp_res;
               ch_ff         <= ch_ff + CH_SEL_BITS'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_status_ff <= status_ff;
               rsp_done_ff   <= done_ff;
               rsp_count_ff  <= COUNT_OUT_BITS'(cnt_ff);
               for (int c = 0; c < NUM_CH; c++) begin
                  rsp_ch_ff[c] <= res_ff[c];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.done_res  = rsp_done_ff;
   assign rsp_bus.key_count = rsp_count_ff;
   assign rsp_bus.out_pos_x = rsp_ch_ff[0];
   assign rsp_bus.out_pos_y = rsp_ch_ff[1];
   assign rsp_bus.out_pos_z = rsp_ch_ff[2];
   assign rsp_bus.out_yaw   = rsp_ch_ff[3];
   assign rsp_bus.out_pitch = rsp_ch_ff[4];
   assign rsp_bus.out_fov   = rsp_ch_ff[5];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_KEYS))
      else $error("key count exceeds table size");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_INS_SHIFT || state_ff == ST_INS_WRITE ||
                 state_ff == ST_DEL_MOVE))
      else $error("table write outside a write state");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_WRITE && !found_ff) |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("new keyframe did not grow the count");

   a_lerp_done: assert property (@(posedge clock) disable iff (reset)
      lerp_done |-> state_ff == ST_EV_WAIT)
      else $error("lerp result outside wait state");

   a_type_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && $past(state_ff) != ST_IDLE) |-> $stable(type_ff))
      else $error("request type changed mid transaction");
`endif
endmodule

// ----- hdl/kti_store.sv -----
// Keyframe table memory: one write port, one read port, registered read data.
// Depends on kti_pkg.
module kti_store import kti_pkg::*; #(
   parameter int MAX_KEYS     = DEF_MAX_KEYS,
   parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
   input  logic                                          clock,
   input  logic                                          rd_en,
   input  logic [$clog2(MAX_KEYS)-1:0]                   rd_addr,
   output logic [KEY_TIME_BITS+NUM_CH*CHANNEL_BITS-1:0]  rd_data,
   input  logic                                          wr_en,
   input  logic [$clog2(MAX_KEYS)-1:0]                   wr_addr,
   input  logic [KEY_TIME_BITS+NUM_CH*CHANNEL_BITS-1:0]  wr_data
);
   localparam int EW = KEY_TIME_BITS + NUM_CH * CHANNEL_BITS;

   logic [EW-1:0] mem [MAX_KEYS];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/kti_lerp.sv -----
// Lerp unit: a + round((b - a) * num / den), one multiply then a
// restoring divide one quotient bit per cycle. Depends on kti_pkg.
module kti_lerp import kti_pkg::*; #(
   parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [CHANNEL_BITS-1:0]    a_val,
   input  logic signed [CHANNEL_BITS-1:0]    b_val,
   input  logic [EVAL_TIME_BITS-1:0]         num,
   input  logic [EVAL_TIME_BITS-1:0]         den,
   output logic                              done,
   output logic signed [CHANNEL_BITS-1:0]    result
);
   localparam int DW  = CHANNEL_BITS + 1;
   localparam int PW  = DW + EVAL_TIME_BITS + 1;
   localparam int NW  = PW + 2;
   localparam int QW  = CHANNEL_BITS + 2;
   localparam int RW  = NW - QW + 1;
   localparam int SW  = $clog2(QW + 1);

   lerp_state_type      state_ff, state_in;
   logic signed [PW-1:0] p_ff;
   logic [RW-1:0]       rem_ff;
   logic [QW-1:0]       lo_ff;
   logic                neg_ff;
   logic [SW-1:0]       step_ff;

   logic signed [DW-1:0] diff;
   logic signed [NW-1:0] n_val;
   logic [NW-1:0]        n_mag;
   logic [RW-1:0]        trial;
   logic [RW-1:0]        dvs;
   logic                 fits;
   logic [QW:0]          q_mag;
   logic signed [QW:0]   q_signed;
   logic signed [QW:0]   sum;

   assign diff  = DW'(b_val) - DW'(a_val);
   assign n_val = (NW'(p_ff) <<< 1) + NW'(signed'({1'b0, den}));
   assign n_mag = n_val[NW-1] ? NW'(-n_val) : NW'(n_val);
   assign trial = {rem_ff[RW-2:0], lo_ff[QW-1]};
   assign dvs   = RW'({den, 1'b0});
   assign fits  = (trial >= dvs);
   assign q_mag = (QW+1)'(lo_ff) + (QW+1)'(neg_ff && (rem_ff != '0));
   assign q_signed = neg_ff ? -signed'(q_mag) : signed'(q_mag);
   assign sum   = (QW+1)'(a_val) + q_signed;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         L_IDLE: if (start) state_in = L_MUL;
         L_MUL:  state_in = L_PREP;
         L_PREP: state_in = L_DIV;
         L_DIV:  if (step_ff == SW'(QW - 1)) state_in = L_OUT;
         L_OUT:  state_in = L_IDLE;
         default: state_in = L_IDLE;
      endcase
   end

   always_comb begin
      done   = (state_ff == L_OUT);
      result = sum[CHANNEL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      unique case (state_ff)
         L_MUL: begin
            p_ff <= diff * signed'({1'b0, num});
         end
         L_PREP: begin
            neg_ff  <= n_val[NW-1];
            rem_ff  <= RW'(n_mag[NW-1:QW]);
            lo_ff   <= n_mag[QW-1:0];
            step_ff <= '0;
         end
         L_DIV: begin
            rem_ff  <= fits ? (trial - dvs) : trial;
            lo_ff   <= {lo_ff[QW-2:0], fits};
            step_ff <= step_ff + SW'(1);
         end
         default: begin
         end
      endcase
   end
endmodule
